[src/swte_pkg.sv]
package swte_pkg;

    // Beat layout on the streams.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;
    localparam int WORD_W    = 16;
    localparam int INDEX_W   = 16;
    localparam int CNT_OUT_W = 11;
    localparam int CFG_W     = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_WRITE   = 3'd1,
        OP_READ    = 3'd2,
        OP_FIND    = 3'd3,
        OP_NEXT    = 3'd4,
        OP_DEL_VAL = 3'd5,
        OP_DEL_IDX = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_RD_WAIT,
        ST_S_READ,
        ST_S_CMP,
        ST_S_END,
        ST_SH_READ,
        ST_SH_WRITE,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        RD_MID,
        RD_IDX,
        RD_MPREV,
        RD_HIGH,
        RD_SHIFT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SWEEP,
        WR_IDX,
        WR_SHIFT,
        WR_TOP
    } wr_sel_t;

    typedef struct packed {
        logic    capture;
        logic    load_count;
        logic    search_init;
        logic    search_cmp;
        logic    shift_init_idx;
        logic    shift_init_mid;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    res_ok;
        logic    res_rv;
        logic    res_ri;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_range;
        logic count_zero;
        logic found;
        logic search_go;
        logic m_zero;
        logic h_neg;
        logic shift_done;
        logic sweep_last;
        logic out_free;
    } status_t;

endpackage

[src/swte_ctrl.sv]
module swte_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  swte_pkg::status_t status,
    output swte_pkg::cmd_t    cmd
);

    swte_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swte_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swte_pkg::ST_INIT: begin
                if (status.sweep_last) state_next = swte_pkg::ST_IDLE;
            end
            swte_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = swte_pkg::ST_DECODE;
            end
            swte_pkg::ST_DECODE: begin
                unique case (status.op)
                    swte_pkg::OP_CLEAR: state_next = swte_pkg::ST_CLEAR;
                    swte_pkg::OP_READ: begin
                        state_next = status.in_range ? swte_pkg::ST_RD_WAIT : swte_pkg::ST_RESP;
                    end
                    swte_pkg::OP_FIND, swte_pkg::OP_NEXT, swte_pkg::OP_DEL_VAL: begin
                        state_next = status.count_zero ? swte_pkg::ST_RESP : swte_pkg::ST_S_READ;
                    end
                    swte_pkg::OP_DEL_IDX: begin
                        state_next = status.in_range ? swte_pkg::ST_SH_READ : swte_pkg::ST_RESP;
                    end
                    default: state_next = swte_pkg::ST_RESP;
                endcase
            end
            swte_pkg::ST_CLEAR: begin
                if (status.sweep_last) state_next = swte_pkg::ST_RESP;
            end
            swte_pkg::ST_RD_WAIT: state_next = swte_pkg::ST_RESP;
            swte_pkg::ST_S_READ: begin
                state_next = status.search_go ? swte_pkg::ST_S_CMP : swte_pkg::ST_S_END;
            end
            swte_pkg::ST_S_CMP: state_next = swte_pkg::ST_S_READ;
            swte_pkg::ST_S_END: begin
                state_next = swte_pkg::ST_RESP;
                priority if (status.op == swte_pkg::OP_NEXT) begin
                    if (status.found ? !status.m_zero : !status.h_neg) begin
                        state_next = swte_pkg::ST_RD_WAIT;
                    end
                end else if (status.op == swte_pkg::OP_DEL_VAL && status.found) begin
                    state_next = swte_pkg::ST_SH_READ;
                end else begin
                    state_next = swte_pkg::ST_RESP;
                end
            end
            swte_pkg::ST_SH_READ: begin
                state_next = status.shift_done ? swte_pkg::ST_RESP : swte_pkg::ST_SH_WRITE;
            end
            swte_pkg::ST_SH_WRITE: state_next = swte_pkg::ST_SH_READ;
            swte_pkg::ST_RESP: begin
                if (status.out_free) state_next = swte_pkg::ST_IDLE;
            end
            default: state_next = swte_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = swte_pkg::RD_MID;
        cmd.wr_sel = swte_pkg::WR_SWEEP;
        s_tready   = 1'b0;
        unique case (state_reg)
            swte_pkg::ST_INIT, swte_pkg::ST_CLEAR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = swte_pkg::WR_SWEEP;
            end
            swte_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            swte_pkg::ST_DECODE: begin
                unique case (status.op)
                    swte_pkg::OP_CLEAR: begin
                        cmd.load_count = 1'b1;
                        cmd.res_ok     = 1'b1;
                    end
                    swte_pkg::OP_WRITE: begin
                        if (status.in_range) begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = swte_pkg::WR_IDX;
                            cmd.res_ok = 1'b1;
                        end
                    end
                    swte_pkg::OP_READ: begin
                        if (status.in_range) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = swte_pkg::RD_IDX;
                        end
                    end
                    swte_pkg::OP_FIND, swte_pkg::OP_NEXT, swte_pkg::OP_DEL_VAL: begin
                        cmd.search_init = !status.count_zero;
                    end
                    swte_pkg::OP_DEL_IDX: begin
                        cmd.shift_init_idx = status.in_range;
                    end
                    default: begin
                    end
                endcase
            end
            swte_pkg::ST_RD_WAIT: begin
                cmd.res_ok = 1'b1;
                cmd.res_rv = 1'b1;
            end
            swte_pkg::ST_S_READ: begin
                if (status.search_go) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = swte_pkg::RD_MID;
                end
            end
            swte_pkg::ST_S_CMP: cmd.search_cmp = 1'b1;
            swte_pkg::ST_S_END: begin
                priority if (status.op == swte_pkg::OP_FIND) begin
                    cmd.res_ok = status.found;
                    cmd.res_ri = status.found;
                end else if (status.op == swte_pkg::OP_NEXT) begin
                    if (status.found) begin
                        cmd.rd_en  = !status.m_zero;
                        cmd.rd_sel = swte_pkg::RD_MPREV;
                    end else begin
                        cmd.rd_en  = !status.h_neg;
                        cmd.rd_sel = swte_pkg::RD_HIGH;
                    end
                end else begin
                    cmd.shift_init_mid = status.found;
                end
            end
            swte_pkg::ST_SH_READ: begin
                if (status.shift_done) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = swte_pkg::WR_TOP;
                    cmd.res_ok = 1'b1;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = swte_pkg::RD_SHIFT;
                end
            end
            swte_pkg::ST_SH_WRITE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = swte_pkg::WR_SHIFT;
            end
            swte_pkg::ST_RESP: cmd.out_load = status.out_free;
            default: begin
            end
        endcase
    end

    // A result must never overwrite a beat that is still waiting downstream.
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.out_load |-> status.out_free)
        else $error("result loaded while output register busy");

endmodule

[src/swte_dp.sv]
module swte_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [swte_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic [swte_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [swte_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swte_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [swte_pkg::M_TUSER_W-1:0]      m_tuser,
    input  swte_pkg::cmd_t                      cmd,
    output swte_pkg::status_t                   status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > swte_pkg::INDEX_W) ? CW : swte_pkg::INDEX_W;
    localparam int LW = (CW > swte_pkg::CFG_W) ? CW : swte_pkg::CFG_W;
    localparam int RESET_COUNT = (CAPACITY < 1024) ? CAPACITY : 1024;
    localparam int WW = swte_pkg::WORD_W;

    logic [WW-1:0] mem [CAPACITY];

    logic [swte_pkg::CFG_W-1:0]   init_len_reg;
    swte_pkg::op_t                op_reg;
    logic [swte_pkg::INDEX_W-1:0] idx_reg;
    logic [WW-1:0]                val_reg;
    logic [CW-1:0]                count_reg;
    logic [AW-1:0]                sweep_reg;
    logic signed [CW:0]           low_reg, high_reg;
    logic [AW-1:0]                mid_reg;
    logic                         found_reg;
    logic [AW-1:0]                k_reg;
    logic [WW-1:0]                rdata_reg;
    logic                         ok_reg;
    logic [WW-1:0]                rv_reg;
    logic [swte_pkg::INDEX_W-1:0] ri_reg;
    logic                         out_valid_reg;
    logic                         out_ok_reg;
    logic [WW-1:0]                out_rv_reg;
    logic [swte_pkg::INDEX_W-1:0] out_ri_reg;
    logic [swte_pkg::CNT_OUT_W-1:0] out_cnt_reg;

    logic [CW-1:0]   count_m1;
    logic [CW-1:0]   idx_slot;
    logic [CW+1:0]   mid_sum;
    logic [AW-1:0]   mid_calc;
    logic [CW-1:0]   clamp_len;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [WW-1:0]   wr_data;
    logic signed [CW:0] mid_ext;

    assign count_m1 = count_reg - CW'(1);
    assign idx_slot = count_m1 - CW'(idx_reg);
    assign mid_sum  = {low_reg[CW], low_reg} + {high_reg[CW], high_reg};
    assign mid_calc = mid_sum[AW:1];
    assign mid_ext  = $signed({{(CW + 1 - AW){1'b0}}, mid_reg});
    assign clamp_len = (LW'(init_len_reg) > LW'(CAPACITY)) ? CW'(CAPACITY) : CW'(init_len_reg);

    always_comb begin
        unique case (cmd.rd_sel)
            swte_pkg::RD_MID:   rd_addr = mid_calc;
            swte_pkg::RD_IDX:   rd_addr = AW'(idx_slot);
            swte_pkg::RD_MPREV: rd_addr = mid_reg - AW'(1);
            swte_pkg::RD_HIGH:  rd_addr = high_reg[AW-1:0];
            swte_pkg::RD_SHIFT: rd_addr = k_reg + AW'(1);
            default:            rd_addr = mid_calc;
        endcase
    end

    always_comb begin
        unique case (cmd.wr_sel)
            swte_pkg::WR_SWEEP: begin
                wr_addr = sweep_reg;
                wr_data = '0;
            end
            swte_pkg::WR_IDX: begin
                wr_addr = AW'(idx_slot);
                wr_data = val_reg;
            end
            swte_pkg::WR_SHIFT: begin
                wr_addr = k_reg;
                wr_data = rdata_reg;
            end
            swte_pkg::WR_TOP: begin
                wr_addr = AW'(count_m1);
                wr_data = '0;
            end
            default: begin
                wr_addr = sweep_reg;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) mem[wr_addr] <= wr_data;
        if (cmd.rd_en) rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_len_reg <= swte_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            init_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(RESET_COUNT);
            sweep_reg <= '0;
        end else begin
            if (cmd.load_count) begin
                count_reg <= clamp_len;
            end else if (cmd.wr_en && cmd.wr_sel == swte_pkg::WR_TOP) begin
                count_reg <= count_m1;
            end
            if (cmd.wr_en && cmd.wr_sel == swte_pkg::WR_SWEEP) begin
                sweep_reg <= status.sweep_last ? '0 : sweep_reg + AW'(1);
            end
        end
    end

    // Item capture, search window and shift pointer.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= swte_pkg::op_t'(s_tuser);
            idx_reg <= s_tdata[swte_pkg::INDEX_W-1:0];
            val_reg <= s_tdata[swte_pkg::INDEX_W +: WW];
        end
        if (cmd.search_init) begin
            low_reg   <= '0;
            high_reg  <= $signed({1'b0, count_reg}) - (CW + 1)'(1);
            found_reg <= 1'b0;
        end else if (cmd.search_cmp) begin
            // Physical slots are descending, so a larger word lies at a lower slot.
            if (rdata_reg == val_reg) begin
                found_reg <= 1'b1;
            end else if (rdata_reg < val_reg) begin
                high_reg <= mid_ext - (CW + 1)'(1);
            end else begin
                low_reg <= mid_ext + (CW + 1)'(1);
            end
        end
        if (cmd.rd_en && cmd.rd_sel == swte_pkg::RD_MID) mid_reg <= mid_calc;
        if (cmd.shift_init_idx) begin
            k_reg <= AW'(idx_slot);
        end else if (cmd.shift_init_mid) begin
            k_reg <= mid_reg;
        end else if (cmd.wr_en && cmd.wr_sel == swte_pkg::WR_SHIFT) begin
            k_reg <= k_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ok_reg <= 1'b0;
            rv_reg <= '0;
            ri_reg <= '0;
        end else begin
            if (cmd.res_ok) ok_reg <= 1'b1;
            if (cmd.res_rv) rv_reg <= rdata_reg;
            if (cmd.res_ri) ri_reg <= swte_pkg::INDEX_W'(count_m1 - CW'(mid_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_ok_reg  <= ok_reg;
            out_rv_reg  <= rv_reg;
            out_ri_reg  <= ri_reg;
            out_cnt_reg <= swte_pkg::CNT_OUT_W'(count_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {
        (swte_pkg::M_TDATA_W - swte_pkg::CNT_OUT_W - swte_pkg::INDEX_W - WW)'(0),
        out_cnt_reg, out_ri_reg, out_rv_reg
    };

    always_comb begin
        status            = '0;
        status.op         = op_reg;
        status.in_range   = XW'(idx_reg) < XW'(count_reg);
        status.count_zero = (count_reg == '0);
        status.found      = found_reg;
        status.search_go  = !found_reg && (low_reg <= high_reg);
        status.m_zero     = (mid_reg == '0);
        status.h_neg      = high_reg[CW];
        status.shift_done = (CW'(k_reg) == count_m1);
        status.sweep_last = (sweep_reg == AW'(CAPACITY - 1));
        status.out_free   = !out_valid_reg || m_tready;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.wr_sel == swte_pkg::WR_TOP) |=> count_reg == $past(count_m1))
        else $error("delete did not shrink the table by one");

    assert property (@(posedge aclk) disable iff (!aresetn) !(cmd.rd_en && cmd.wr_en))
        else $error("memory read and write issued together");

endmodule

[src/sorted_word_table_engine.sv]
// Sorted word table: a store of CAPACITY 16-bit words, kept in descending physical
// order with logical index i at slot count-1-i, supporting clear, write, read, find,
// next-larger and delete by value or index, one operation per input beat and one
// result beat each. Items are handled one at a time, paced by the single-port word
// memory: find runs a binary search with a read and a compare per probe, next may
// then read the neighboring word, delete moves each entry above the deleted slot
// down by one and zeroes the top slot, and clear zeroes every slot.
// After reset the block runs the same zeroing pass with s_tready low; configuration
// writes are taken throughout. A finished result waits in an output register, and
// the next beat is accepted while it waits.
module sorted_word_table_engine #(
    parameter int CAPACITY = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swte_pkg::CFG_W-1:0]     cfg_wr_data,   // initial_length
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swte_pkg::S_TDATA_W-1:0] s_tdata,       // index[15:0], value[31:16]
    input  logic [swte_pkg::S_TUSER_W-1:0] s_tuser,       // op[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swte_pkg::M_TDATA_W-1:0] m_tdata,       // result_value[15:0],
                                                          // result_index[31:16],
                                                          // entry_count[42:32]
    output logic [swte_pkg::M_TUSER_W-1:0] m_tuser        // ok[0]
);

    swte_pkg::cmd_t    cmd;
    swte_pkg::status_t status;

    swte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swte_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
